// ===== hdl/delayed_threshold_alarm_macros.svh =====
// ---------------------------------------------------------------------------
// delayed_threshold_alarm_macros.svh
// Assertion macros for the alarm block's checker.
// ---------------------------------------------------------------------------
`ifndef DELAYED_THRESHOLD_ALARM_MACROS_SVH
`define DELAYED_THRESHOLD_ALARM_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DTA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/dta_pkg.sv =====
// ---------------------------------------------------------------------------
// dta_pkg
// Types and constants of the delayed threshold alarm.
// ---------------------------------------------------------------------------
package dta_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TAG  = 3'd6;

    // alarm status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_HIGH   = 2'd1;
    localparam logic [1:0] ST_LOW    = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic               high_enable;
        logic               low_enable;
        logic signed [15:0] high_limit;
        logic signed [15:0] low_limit;
        logic [14:0]        hysteresis;
        logic [31:0]        delay_ms;
        logic [7:0]         source_tag;
    } cfg_t;

    // events produced by one sample
    typedef struct packed {
        logic [1:0] count;
        logic [1:0] status0;
        logic [1:0] status1;
    } ev_t;

endpackage

// ===== hdl/delayed_threshold_alarm.sv =====
// ---------------------------------------------------------------------------
// delayed_threshold_alarm
// High/low threshold alarm with breach delay, hysteresis and status events.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_ready  | sample (s16), now_ms (u32)
//  out     | out_valid / out_ready| tag (u8), new_status (u2), last
//  cfg     | cfg_we               | cfg_index (3b), cfg_data (32b)
//
//  An accepted sample lands in the input register; once the result register
//  has space, the alarm update runs in one pass and its 0..2 events load it.
//  Sustained rate is one sample per cycle while samples yield at most one
//  event and out_ready stays high; a sample that yields two events holds
//  the result register until out_ready has taken both, which bounds the rate.
//  Reset clears the alarm state, the pending breaches and loads the register
//  reset values; out_valid stalls hold the input register and then in_ready.
// ---------------------------------------------------------------------------
module delayed_threshold_alarm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [15:0]             sample,
    input  logic [31:0]                    now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     tag,
    output logic [1:0]                     new_status,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [dta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dta_pkg::CFG_DATA_W-1:0] cfg_data
);

    dta_pkg::cfg_t cfg;
    dta_pkg::ev_t  ev;

    logic               s1_valid_reg, s1_valid_next;
    logic signed [15:0] s1_sample_reg;
    logic [31:0]        s1_now_reg;
    logic               space;
    logic               go;
    logic               accept;

    // run the update when the result register will be free to take its events
    assign go       = s1_valid_reg && space;
    assign in_ready = !s1_valid_reg || go;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (go)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // hold the payload of the sample in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_now_reg    <= now_ms;
        end
    end

    dta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dta_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .sample (s1_sample_reg),
        .now_ms (s1_now_reg),
        .cfg    (cfg),
        .ev     (ev)
    );

    dta_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (go),
        .ev         (ev),
        .load_tag   (cfg.source_tag),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tag        (tag),
        .new_status (new_status),
        .last       (last)
    );

endmodule

// ===== hdl/dta_cfg.sv =====
// ---------------------------------------------------------------------------
// dta_cfg
// Configuration register file with plain write port.
// ---------------------------------------------------------------------------
module dta_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dta_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dta_pkg::cfg_t                    cfg
);

    dta_pkg::cfg_t cfg_reg;
    dta_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dta_pkg::REG_HIGH_ENABLE: cfg_next.high_enable = cfg_data[0];
                dta_pkg::REG_LOW_ENABLE:  cfg_next.low_enable  = cfg_data[0];
                dta_pkg::REG_HIGH_LIMIT:  cfg_next.high_limit  = cfg_data[15:0];
                dta_pkg::REG_LOW_LIMIT:   cfg_next.low_limit   = cfg_data[15:0];
                dta_pkg::REG_HYSTERESIS:  cfg_next.hysteresis  = cfg_data[14:0];
                dta_pkg::REG_DELAY_MS:    cfg_next.delay_ms    = cfg_data[31:0];
                dta_pkg::REG_SOURCE_TAG:  cfg_next.source_tag  = cfg_data[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_enable <= 1'b0;
            cfg_reg.low_enable  <= 1'b0;
            cfg_reg.high_limit  <= 16'sh7FFF;
            cfg_reg.low_limit   <= 16'sh8000;
            cfg_reg.hysteresis  <= '0;
            cfg_reg.delay_ms    <= '0;
            cfg_reg.source_tag  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/dta_step.sv =====
// ---------------------------------------------------------------------------
// dta_step
// Alarm state and the per-sample update with its event list.
// ---------------------------------------------------------------------------
module dta_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [15:0] sample,
    input  logic [31:0]        now_ms,
    input  dta_pkg::cfg_t      cfg,
    output dta_pkg::ev_t       ev
);

    logic [1:0]  alarm_state_reg, alarm_state_next;
    logic        high_pending_reg, high_pending_next;
    logic [31:0] high_start_reg, high_start_next;
    logic        low_pending_reg, low_pending_next;
    logic [31:0] low_start_reg, low_start_next;

    logic signed [16:0] s_ext;
    logic signed [16:0] high_clear;
    logic signed [16:0] low_clear;

    assign s_ext      = {sample[15], sample};
    assign high_clear = {cfg.high_limit[15], cfg.high_limit} - $signed({2'b00, cfg.hysteresis});
    assign low_clear  = {cfg.low_limit[15], cfg.low_limit} + $signed({2'b00, cfg.hysteresis});

    always_comb
    begin
        logic [1:0]  st;
        logic        hp;
        logic [31:0] hs;
        logic        lp;
        logic [31:0] ls;
        logic [1:0]  n;
        logic [1:0]  e0;
        logic [1:0]  e1;

        st = alarm_state_reg;
        hp = high_pending_reg;
        hs = high_start_reg;
        lp = low_pending_reg;
        ls = low_start_reg;
        n  = 2'd0;
        e0 = dta_pkg::ST_NONE;
        e1 = dta_pkg::ST_NONE;

        // high side
        if (cfg.high_enable)
        begin
            if (!hp && (sample >= cfg.high_limit))
            begin
                hp = 1'b1;
                hs = now_ms;
            end
            if (hp && (sample < cfg.high_limit) && (st == dta_pkg::ST_NONE))
                hp = 1'b0;
            if (hp && (st == dta_pkg::ST_NONE) && ((now_ms - hs) >= cfg.delay_ms))
            begin
                st = dta_pkg::ST_HIGH;
                if (n == 2'd0) e0 = st; else e1 = st;
                n = n + 2'd1;
            end
            if ((st == dta_pkg::ST_HIGH) && (s_ext < high_clear))
            begin
                st = dta_pkg::ST_NONE;
                hp = 1'b0;
                if (n == 2'd0) e0 = st; else e1 = st;
                n = n + 2'd1;
            end
        end
        // drop a high alarm whose side is off
        if ((st == dta_pkg::ST_HIGH) && !cfg.high_enable)
        begin
            st = dta_pkg::ST_NONE;
            hp = 1'b0;
            if (n == 2'd0) e0 = st; else e1 = st;
            n = n + 2'd1;
        end

        // low side
        if (cfg.low_enable)
        begin
            if (!lp && (sample <= cfg.low_limit))
            begin
                lp = 1'b1;
                ls = now_ms;
            end
            if (lp && (sample > cfg.low_limit) && (st == dta_pkg::ST_NONE))
                lp = 1'b0;
            if (lp && (st == dta_pkg::ST_NONE) && ((now_ms - ls) >= cfg.delay_ms))
            begin
                st = dta_pkg::ST_LOW;
                if (n == 2'd0) e0 = st; else e1 = st;
                n = n + 2'd1;
            end
            if ((st == dta_pkg::ST_LOW) && (s_ext > low_clear))
            begin
                st = dta_pkg::ST_NONE;
                lp = 1'b0;
                if (n == 2'd0) e0 = st; else e1 = st;
                n = n + 2'd1;
            end
        end
        if ((st == dta_pkg::ST_LOW) && !cfg.low_enable)
        begin
            st = dta_pkg::ST_NONE;
            lp = 1'b0;
            if (n == 2'd0) e0 = st; else e1 = st;
            n = n + 2'd1;
        end

        alarm_state_next  = st;
        high_pending_next = hp;
        high_start_next   = hs;
        low_pending_next  = lp;
        low_start_next    = ls;
        ev.count   = n;
        ev.status0 = e0;
        ev.status1 = e1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_state_reg  <= dta_pkg::ST_NONE;
            high_pending_reg <= 1'b0;
            high_start_reg   <= '0;
            low_pending_reg  <= 1'b0;
            low_start_reg    <= '0;
        end
        else if (go)
        begin
            alarm_state_reg  <= alarm_state_next;
            high_pending_reg <= high_pending_next;
            high_start_reg   <= high_start_next;
            low_pending_reg  <= low_pending_next;
            low_start_reg    <= low_start_next;
        end
    end

endmodule

// ===== hdl/dta_evq.sv =====
// ---------------------------------------------------------------------------
// dta_evq
// Two-entry result register that delivers a sample's events in order.
// ---------------------------------------------------------------------------
module dta_evq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  dta_pkg::ev_t  ev,
    input  logic [7:0]    load_tag,
    output logic          space,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    tag,
    output logic [1:0]    new_status,
    output logic          last
);

    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] slot0_reg, slot0_next;
    logic [1:0] slot1_reg, slot1_next;
    logic [7:0] tag_reg, tag_next;
    logic       pop;

    assign pop   = (cnt_reg != 2'd0) && out_ready;
    assign space = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        tag_next   = tag_reg;
        if (pop)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
        // load only happens once the queue drains this cycle
        if (load)
        begin
            cnt_next = ev.count;
            if (ev.count != 2'd0)
            begin
                slot0_next = ev.status0;
                slot1_next = ev.status1;
                tag_next   = load_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        tag_reg   <= tag_next;
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign new_status = slot0_reg;
    assign last       = (cnt_reg == 2'd1);
    assign tag        = tag_reg;

endmodule

// ===== hdl/dta_checker.sv =====
// ---------------------------------------------------------------------------
// dta_checker
// Port-level checks on the alarm block, bound to the top level.
// ---------------------------------------------------------------------------
`include "delayed_threshold_alarm_macros.svh"

module dta_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [15:0] sample,
    input logic [31:0]        now_ms,
    input logic               out_valid,
    input logic               out_ready,
    input logic [7:0]         tag,
    input logic [1:0]         new_status,
    input logic               last
);

    // hold an offered sample until it is taken
    `DTA_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(now_ms), "offered sample dropped or changed")

    // hold a stalled event
    `DTA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(new_status) && $stable(last) && $stable(tag), "stalled event changed")

    `DTA_ASSERT(a_no_bad_code, out_valid |-> new_status != dta_pkg::ST_UNUSED, "unused status code emitted")

    // a non-final event is followed at once by the rest of its sample
    `DTA_ASSERT(a_pair_follows, out_valid && out_ready && !last |=> out_valid && new_status != $past(new_status), "second event missing or repeats status")

    // the result side is cleared asynchronously by reset
    `DTA_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid, "event shown during reset")

endmodule

bind delayed_threshold_alarm dta_checker u_dta_checker (.*);
